>>> src/wopl_pkg.sv
// ----------------------------------------------------------------------------
// wopl_pkg: shared types and constants
// Word formats for the request and response channels, the queue entry that
// travels from the front end to the back end, and fixed field widths.
// ----------------------------------------------------------------------------
package wopl_pkg;

   localparam int COORD_BITS = 16;
   localparam int SLOT_BITS  = 4;
   localparam int FILL_BITS  = 8;
   localparam int COUNT_BITS = 5;

   localparam logic [FILL_BITS-1:0] SPACE_CODE = 8'd32;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [SLOT_BITS-1:0]  slot;
      logic [COORD_BITS-1:0] win_x_low;
      logic [COORD_BITS-1:0] win_y_low;
      logic [COORD_BITS-1:0] win_x_high;
      logic [COORD_BITS-1:0] win_y_high;
      logic [FILL_BITS-1:0]  win_fill;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [FILL_BITS-1:0] pixel_char;
      logic                 covered;
   } rsp_type;

   typedef enum logic {
      OP_WRITE,
      OP_LOOKUP
   } op_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x_low;
      logic [COORD_BITS-1:0] y_low;
      logic [COORD_BITS-1:0] x_high;
      logic [COORD_BITS-1:0] y_high;
      logic [FILL_BITS-1:0]  fill;
   } window_type;

   typedef struct packed {
      op_type                op;
      logic [SLOT_BITS-1:0]  slot;
      window_type            win;
      logic [COORD_BITS-1:0] px;
      logic [COORD_BITS-1:0] py;
   } entry_type;

endpackage

>>> src/wopl_front.sv
// ----------------------------------------------------------------------------
// wopl_front: request front end
// Takes request words, sorts them into table writes and pixel lookups, drops
// writes aimed at inactive slots and pushes the rest into the work queue.
// ----------------------------------------------------------------------------
module wopl_front #(
   parameter int MAX_WINDOWS = 16
) (
   input  logic                            reset,
   input  logic                            start,
   input  wopl_pkg::req_type               req,
   input  logic [wopl_pkg::COUNT_BITS-1:0] window_count,
   input  logic                            queue_full,
   output logic                            busy,
   output logic                            push,
   output wopl_pkg::entry_type             push_data
);
   import wopl_pkg::*;

   logic accept;
   logic slot_ok;

   assign busy    = reset | queue_full;
   assign accept  = start & ~busy;
   // a write only lands in a slot that is active and exists in the table
   assign slot_ok = (int'(req.slot) < int'(window_count)) && (int'(req.slot) < MAX_WINDOWS);
   assign push    = accept && ((req.cmd == CMD_LOOKUP) || slot_ok);

   always_comb begin
      push_data.op          = (req.cmd == CMD_LOOKUP) ? OP_LOOKUP : OP_WRITE;
      push_data.slot        = req.slot;
      push_data.win.x_low   = req.win_x_low;
      push_data.win.y_low   = req.win_y_low;
      push_data.win.x_high  = req.win_x_high;
      push_data.win.y_high  = req.win_y_high;
      push_data.win.fill    = req.win_fill;
      push_data.px          = req.pixel_x;
      push_data.py          = req.pixel_y;
   end

endmodule

>>> src/wopl_queue.sv
// ----------------------------------------------------------------------------
// wopl_queue: work queue
// Small first-in first-out queue of classified words between the front end
// and the back end.
// ----------------------------------------------------------------------------
module wopl_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wopl_pkg::entry_type push_data,
   input  logic                pop,
   output logic                empty,
   output logic                full,
   output wopl_pkg::entry_type head
);
   import wopl_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   entry_type             slot_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  push_ok;
   logic                  pop_ok;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_BITS'(DEPTH));
   assign push_ok = push & ~full;
   assign pop_ok  = pop & ~empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/wopl_back.sv
// ----------------------------------------------------------------------------
// wopl_back: window table and lookup back end
// Holds the window table. Pops one word a clock: writes update a table slot,
// lookups compare the pixel against every window in parallel, then pick the
// highest-numbered covering window in a second stage.
// ----------------------------------------------------------------------------
module wopl_back #(
   parameter int MAX_WINDOWS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  wopl_pkg::entry_type             head,
   input  logic [wopl_pkg::COUNT_BITS-1:0] window_count,
   output logic                            pop,
   output logic                            rsp_valid,
   output wopl_pkg::rsp_type               rsp
);
   import wopl_pkg::*;

   window_type             win_ff [MAX_WINDOWS];
   logic [MAX_WINDOWS-1:0] hit_ff, hit_in;
   logic                   hit_valid_ff, hit_valid_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   assign pop          = head_valid;
   assign hit_valid_in = head_valid && (head.op == OP_LOOKUP);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp          = rsp_ff;

   // per-window coverage test, inactive slots never hit
   always_comb begin
      for (int j = 0; j < MAX_WINDOWS; j++) begin
         hit_in[j] = (j < int'(window_count)) &&
                     (win_ff[j].y_low <= head.py) && (head.py <= win_ff[j].y_high) &&
                     (win_ff[j].x_low <= head.px) && (head.px <= win_ff[j].x_high);
      end
   end

   // later windows paint over earlier ones
   always_comb begin
      rsp_in.pixel_char = SPACE_CODE;
      rsp_in.covered    = |hit_ff;
      for (int j = 0; j < MAX_WINDOWS; j++) begin
         if (hit_ff[j]) begin
            rsp_in.pixel_char = win_ff[j].fill;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_valid_ff <= hit_valid_in;
         rsp_valid_ff <= hit_valid_ff;
      end
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MAX_WINDOWS; j++) begin
         if (head_valid && (head.op == OP_WRITE) && (int'(head.slot) == j)) begin
            win_ff[j] <= head.win;
         end
      end
   end

endmodule

>>> src/window_overlay_pixel_lookup.sv
// ----------------------------------------------------------------------------
// window_overlay_pixel_lookup: rectangle overlay pixel lookup
// Keeps a table of rectangular windows and returns, for each pixel, the fill
// of the topmost window that covers it.
// ----------------------------------------------------------------------------
// One word is taken every clock. A lookup word passes through the work queue,
// the registered parallel window compares and the registered topmost-window
// select before its response comes out; a table write gives no response and
// is seen by every lookup taken after it. The back end drains the work queue
// at one word a clock and the receiver cannot stall, so busy is high only
// during reset. The user must write the window count through csr_we only while
// no word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module window_overlay_pixel_lookup #(
   parameter int MAX_WINDOWS = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  wopl_pkg::req_type               req_word,
   output logic                            rsp_valid,
   output wopl_pkg::rsp_type               rsp_word,
   input  logic                            csr_we,
   input  logic [wopl_pkg::COUNT_BITS-1:0] csr_wdata
);
   import wopl_pkg::*;

   logic [COUNT_BITS-1:0] window_count_ff, window_count_in;
   logic                  push;
   entry_type             push_data;
   logic                  queue_full;
   logic                  queue_empty;
   logic                  pop;
   entry_type             head;

   assign window_count_in = csr_we ? csr_wdata : window_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= '0;
      end else begin
         window_count_ff <= window_count_in;
      end
   end

   wopl_front #(
      .MAX_WINDOWS (MAX_WINDOWS)
   ) u_front (
      .reset        (reset),
      .start        (start),
      .req          (req_word),
      .window_count (window_count_ff),
      .queue_full   (queue_full),
      .busy         (busy),
      .push         (push),
      .push_data    (push_data)
   );

   wopl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .empty     (queue_empty),
      .full      (queue_full),
      .head      (head)
   );

   wopl_back #(
      .MAX_WINDOWS (MAX_WINDOWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (~queue_empty),
      .head         (head),
      .window_count (window_count_ff),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp_word)
   );

endmodule

>>> src/wopl_checker.sv
// ----------------------------------------------------------------------------
// wopl_checker: port-level checks
// Watches the top-level ports: response timing per lookup word, quiet
// response channel and low busy after reset, and the no-cover character.
// ----------------------------------------------------------------------------
module wopl_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input wopl_pkg::req_type req,
   input logic              rsp_valid,
   input wopl_pkg::rsp_type rsp
);
   import wopl_pkg::*;

   logic accept;

   assign accept = start & ~busy;

   // each lookup word taken gives exactly one response, writes none
   a_rsp_timing: assert property (@(posedge clock) disable iff (reset)
      !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) |->
         rsp_valid == ($past(accept, 3) && ($past(req.cmd, 3) == CMD_LOOKUP)))
      else $error("response strobe does not match lookup word taken three clocks earlier");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response strobe right after reset");

   a_space_when_uncovered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.covered |-> rsp.pixel_char == SPACE_CODE)
      else $error("uncovered pixel did not return a space");

   a_busy_only_in_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !busy)
      else $error("busy high right after reset");

endmodule

bind window_overlay_pixel_lookup wopl_checker u_wopl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req       (req_word),
   .rsp_valid (rsp_valid),
   .rsp       (rsp_word)
);

>>> tb/tb_window_overlay_pixel_lookup.sv
// ----------------------------------------------------------------------------
// tb_window_overlay_pixel_lookup: window overlay lookup testbench
// Drives table writes and pixel lookups through the start/busy handshake.
// A shadow window table predicts the topmost fill for every lookup, and
// each response is checked in order against it. The window count is changed
// between phases, and sender gaps vary from none to heavy.
// ----------------------------------------------------------------------------
module tb_window_overlay_pixel_lookup;
   import wopl_pkg::*;

   localparam int TABLE_SLOTS    = 16;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_WORDS    = 170;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req       = '0;
   logic                  rsp_valid;
   rsp_type               rsp;
   logic                  csr_we    = 1'b0;
   logic [COUNT_BITS-1:0] csr_wdata = '0;

   // shadow of the window table and the pixels still owed by the block
   class overlay_scoreboard;
      window_type            win_table [TABLE_SLOTS];
      logic [COUNT_BITS-1:0] window_count;
      rsp_type               expected_pixels [$];
      int                    mismatches;
      int                    lookups_checked;
      int                    writes_stored;
      int                    writes_dropped;

      function new();
         window_count = '0;
         foreach (win_table[i]) win_table[i] = '0;
         mismatches      = 0;
         lookups_checked = 0;
         writes_stored   = 0;
         writes_dropped  = 0;
      endfunction

      function void write_count(logic [COUNT_BITS-1:0] value);
         window_count = value;
      endfunction

      function int active_slots();
         return (int'(window_count) > TABLE_SLOTS) ? TABLE_SLOTS : int'(window_count);
      endfunction

      function void note_word(req_type w);
         int      active;
         rsp_type pixel;
         active = active_slots();
         if (w.cmd == CMD_WRITE) begin
            if (int'(w.slot) < active) begin
               win_table[w.slot] = '{x_low: w.win_x_low, y_low: w.win_y_low,
                                     x_high: w.win_x_high, y_high: w.win_y_high,
                                     fill: w.win_fill};
               writes_stored++;
            end else begin
               writes_dropped++;
            end
         end else begin
            pixel.pixel_char = SPACE_CODE;
            pixel.covered    = 1'b0;
            // later slots paint over earlier ones
            for (int j = 0; j < active; j++) begin
               if (win_table[j].y_low <= w.pixel_y && w.pixel_y <= win_table[j].y_high &&
                   win_table[j].x_low <= w.pixel_x && w.pixel_x <= win_table[j].x_high) begin
                  pixel.pixel_char = win_table[j].fill;
                  pixel.covered    = 1'b1;
               end
            end
            expected_pixels.push_back(pixel);
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         if (mismatches < 40)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_pixel(rsp_type got);
         rsp_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("response with no lookup pending", int'(got), 0);
         end else begin
            want = expected_pixels.pop_front();
            lookups_checked++;
            if (got.pixel_char !== want.pixel_char)
               report_mismatch("pixel_char", int'(got.pixel_char), int'(want.pixel_char));
            if (got.covered !== want.covered)
               report_mismatch("covered", int'(got.covered), int'(want.covered));
         end
      endtask
   endclass

   overlay_scoreboard sb = new();
   int                idle_cycles = 0;
   int                counts_used = 0;

   window_overlay_pixel_lookup u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // monitor: values read here are the ones the block sees at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_pixel(rsp);
         if (csr_we) sb.write_count(csr_wdata);
         if (start && !busy) sb.note_word(req);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_window_overlay_pixel_lookup failed");
            $finish;
         end
      end
   end

   task automatic send_word(input req_type w);
      req   <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // wait out every lookup in flight, then let trailing writes land
   task automatic drain_all();
      start <= 1'b0;
      while (sb.expected_pixels.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic change_count(input logic [COUNT_BITS-1:0] value);
      drain_all();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      counts_used++;
   endtask

   function automatic req_type make_window(input int slot, input logic [15:0] xl,
                                           input logic [15:0] yl, input logic [15:0] xh,
                                           input logic [15:0] yh, input logic [7:0] fill);
      req_type w;
      w            = '0;
      w.cmd        = CMD_WRITE;
      w.slot       = 4'(slot);
      w.win_x_low  = xl;
      w.win_y_low  = yl;
      w.win_x_high = xh;
      w.win_y_high = yh;
      w.win_fill   = fill;
      return w;
   endfunction

   function automatic req_type make_pixel(input logic [15:0] x, input logic [15:0] y);
      req_type w;
      w         = '0;
      w.cmd     = CMD_LOOKUP;
      w.pixel_x = x;
      w.pixel_y = y;
      return w;
   endfunction

   function automatic logic [15:0] near_bound(input logic [15:0] lo, input logic [15:0] hi);
      case ($urandom_range(0, 4))
         0: return lo - 16'd1;
         1: return lo;
         2: return hi;
         3: return hi + 16'd1;
         default: return lo + ((hi - lo) >> 1);
      endcase
   endfunction

   function automatic req_type random_word();
      req_type    w;
      window_type aim;
      int         pick;
      int         active;
      w.cmd        = ($urandom_range(0, 99) < 35) ? CMD_WRITE : CMD_LOOKUP;
      w.slot       = 4'($urandom_range(0, 15));
      w.win_x_low  = 16'($urandom);
      w.win_y_low  = 16'($urandom);
      w.win_x_high = 16'($urandom);
      w.win_y_high = 16'($urandom);
      w.win_fill   = 8'($urandom);
      w.pixel_x    = 16'($urandom);
      w.pixel_y    = 16'($urandom);
      pick         = $urandom_range(0, 99);
      if (w.cmd == CMD_WRITE) begin
         active = sb.active_slots();
         if (active > 0 && $urandom_range(0, 99) < 80)
            w.slot = 4'($urandom_range(0, active - 1));
         if (pick < 60) begin
            // small overlapping windows near the origin
            w.win_x_low  = 16'($urandom_range(0, 63));
            w.win_y_low  = 16'($urandom_range(0, 63));
            w.win_x_high = w.win_x_low + 16'($urandom_range(0, 40));
            w.win_y_high = w.win_y_low + 16'($urandom_range(0, 40));
         end else if (pick < 70) begin
            // empty on one axis, unless the high bound wraps below zero
            w.win_x_low  = 16'($urandom_range(1, 63));
            w.win_y_low  = 16'($urandom_range(0, 63));
            w.win_x_high = w.win_x_low - 16'($urandom_range(1, 8));
            w.win_y_high = w.win_y_low + 16'($urandom_range(0, 20));
            if ($urandom_range(0, 1) == 1) begin
               w.win_x_high = w.win_x_low + 16'($urandom_range(0, 20));
               w.win_y_high = w.win_y_low - 16'd1;
            end
         end else if (pick < 85) begin
            // windows hugging the far corner
            w.win_x_high = 16'hFFFF - 16'($urandom_range(0, 30));
            w.win_y_high = 16'hFFFF - 16'($urandom_range(0, 30));
            w.win_x_low  = w.win_x_high - 16'($urandom_range(0, 2000));
            w.win_y_low  = w.win_y_high - 16'($urandom_range(0, 2000));
         end
      end else begin
         if (pick < 55) begin
            aim       = sb.win_table[$urandom_range(0, TABLE_SLOTS - 1)];
            w.pixel_x = near_bound(aim.x_low, aim.x_high);
            w.pixel_y = near_bound(aim.y_low, aim.y_high);
         end else if (pick < 62) begin
            w.pixel_x = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            w.pixel_y = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
         end else if (pick < 85) begin
            w.pixel_x = 16'($urandom_range(0, 80));
            w.pixel_y = 16'($urandom_range(0, 80));
         end
      end
      return w;
   endfunction

   initial begin
      int phase_count [8];
      int gap_pct [3];
      int pct;
      int gap;

      phase_count = '{16, 31, 5, 0, 1, 17, 16, 0};
      phase_count[7] = $urandom_range(2, 15);
      gap_pct = '{0, 87, 13};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no active windows: every pixel is blank and writes are dropped
      change_count(0);
      send_word(make_pixel(16'h0000, 16'h0000));
      send_word(make_window(0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'h41));

      // full table so that no lookup ever reaches an unwritten slot
      change_count(16);
      send_word(make_window(0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_word(make_window(1, 16'h0005, 16'h0000, 16'h0004, 16'hFFFF, 8'h42));
      send_word(make_window(2, 16'h0000, 16'h0009, 16'hFFFF, 16'h0008, 8'h43));
      send_word(make_window(3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00));
      send_word(make_window(4, 16'd10, 16'd10, 16'd20, 16'd20, 8'h61));
      for (int s = 5; s < 15; s++)
         send_word(make_window(s, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 8'(s)));
      send_word(make_window(15, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h55));
      send_word(make_pixel(16'h0000, 16'h0000));
      send_word(make_pixel(16'hFFFF, 16'hFFFF));
      send_word(make_pixel(16'd15, 16'd15));
      send_word(make_pixel(16'd21, 16'd15));

      // slot 4 drops out; a write beyond the count leaves the table alone
      change_count(3);
      send_word(make_window(9, 16'd0, 16'd0, 16'd100, 16'd100, 8'h5A));
      send_word(make_pixel(16'd15, 16'd15));

      // count above the table size acts as a full table
      change_count(31);
      send_word(make_pixel(16'hFFFF, 16'hFFFF));

      for (int p = 0; p < 8; p++) begin
         change_count(5'(phase_count[p]));
         pct = gap_pct[p % 3];
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ($urandom_range(0, 199) == 0) drain_all();
            send_word(random_word());
            gap = 0;
            while (pct > 0 && $urandom_range(0, 99) < pct) gap++;
            idle_for(gap);
         end
      end

      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d window counts: %0d lookups checked, %0d windows stored, %0d writes dropped",
               counts_used, sb.lookups_checked, sb.writes_stored, sb.writes_dropped);
      $display("mismatches: %0d, lookups outstanding: %0d",
               sb.mismatches, sb.expected_pixels.size());
      if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
         $display("tb_window_overlay_pixel_lookup passed");
      end else begin
         $display("tb_window_overlay_pixel_lookup failed");
      end
      $finish;
   end

endmodule
